### src/clsr_pkg.sv
`timescale 1ns / 1ps

package clsr_pkg;

	localparam int TABLE_SIZE_DEF = 32;
	localparam int WARMUP_DEF     = 8;

	localparam int VAL_W  = 31;
	localparam int FRAC_W = 24;
	localparam int MUL_W  = 16;

	localparam logic [VAL_W-1:0] GEN1_MOD  = 31'd2147483563;
	localparam logic [VAL_W-1:0] GEN2_MOD  = 31'd2147483399;
	localparam logic [MUL_W-1:0] GEN1_MUL  = 16'd40014;
	localparam logic [MUL_W-1:0] GEN2_MUL  = 16'd40692;
	localparam logic [VAL_W-1:0] GEN1_RST  = 31'd1;
	localparam logic [VAL_W-1:0] GEN2_RST  = 31'd123456789;
	localparam logic [VAL_W-1:0] WRAP_ADD  = 31'd2147483562;
	localparam logic [FRAC_W-1:0] FRAC_MAX = 24'd16777214;

	// 2^31 - GEN1_MOD, used when scaling to the 0.24 fraction
	localparam logic [31:0] GEN1_FOLD = 32'h8000_0000 - {1'b0, GEN1_MOD};

	typedef struct packed {
		logic seed;      // load both generators from the seed, arm fill counter
		logic warm;      // one warm-up step of generator 1, fill table
		logic step;      // advance both generators
		logic upd;       // combine with table slot, refill slot
		logic out_load;  // capture result into output register
	} ctl_t;

	typedef struct packed {
		logic warm_last; // fill counter at zero: this warm step is the last
	} stat_t;

endpackage

### src/clsr_mulmod.sv
`timescale 1ns / 1ps

module clsr_mulmod #(
	parameter logic [15:0] MUL = 16'd40014,
	parameter logic [30:0] MOD = 31'd2147483563
) (
	input  logic        clk,
	input  logic [30:0] x,
	output logic [30:0] y
);
	import clsr_pkg::*;

	// modulus is 2^31 - FOLD, FOLD small
	localparam logic [7:0] FOLD = 8'(32'h8000_0000 - {1'b0, MOD});

	logic [46:0] prod_s1;
	logic [23:0] hi_fold;
	logic [31:0] sum;

	always_ff @(posedge clk) begin
		prod_s1 <= {16'b0, x} * {31'b0, MUL};
	end

	always_comb begin
		hi_fold = prod_s1[46:31] * FOLD;
		sum     = {1'b0, prod_s1[30:0]} + {8'b0, hi_fold};
		if (sum >= {1'b0, MOD}) begin
			y = 31'(sum - {1'b0, MOD});
		end else begin
			y = sum[30:0];
		end
	end

endmodule

### src/clsr_datapath.sv
`timescale 1ns / 1ps

module clsr_datapath #(
	parameter int TABLE_SIZE    = 32,
	parameter int WARMUP_ROUNDS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  clsr_pkg::ctl_t      ctl,
	output clsr_pkg::stat_t     stat,
	input  logic [30:0]         seed_value,
	output logic [30:0]         value_integer,
	output logic [23:0]         value_fraction
);
	import clsr_pkg::*;

	localparam int IDX_W   = $clog2(TABLE_SIZE);
	localparam int CNT_W   = $clog2(TABLE_SIZE + WARMUP_ROUNDS);
	localparam int TOP_CNT = TABLE_SIZE + WARMUP_ROUNDS - 1;
	localparam logic [31:0] SLOT_DIV = 32'(1 + 2147483562 / TABLE_SIZE);

	logic [VAL_W-1:0] gen1_q, gen2_q, last_q, rd_q;
	logic [VAL_W-1:0] gen1_nx, gen2_nx, seed_fix, val;
	logic [CNT_W-1:0] cnt_q;
	logic [TABLE_SIZE-1:0] valid_q;
	logic [VAL_W-1:0] mem [TABLE_SIZE];

	logic [IDX_W-1:0] q0_q, slot_q, slot_nx;
	logic [31+IDX_W:0] slot_prod;
	logic [31:0] bound;
	logic [IDX_W:0] slot_est;

	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [VAL_W-1:0] wr_data;

	logic [32:0] diff, diff_wrap;
	logic [23:0] f0;
	logic [31:0] f_lhs, f_rhs;
	logic [24:0] f_sum;
	logic [23:0] frac;
	logic [30:0] int_q;
	logic [23:0] frac_q;

	clsr_mulmod #(.MUL(GEN1_MUL), .MOD(GEN1_MOD)) u_gen1 (
		.clk (clk),
		.x   (gen1_q),
		.y   (gen1_nx)
	);

	clsr_mulmod #(.MUL(GEN2_MUL), .MOD(GEN2_MOD)) u_gen2 (
		.clk (clk),
		.x   (gen2_q),
		.y   (gen2_nx)
	);

	assign seed_fix       = (seed_value == '0) ? GEN1_RST : seed_value;
	assign stat.warm_last = (cnt_q == '0);

	// slot = last / SLOT_DIV: last*N >> 31 is low by at most one
	always_comb begin
		slot_prod = {{(IDX_W+1){1'b0}}, last_q} * (32+IDX_W)'(TABLE_SIZE);
		bound     = (32'(q0_q) + 32'd1) * SLOT_DIV;
		slot_est  = {1'b0, q0_q} + (IDX_W+1)'({1'b0, last_q} >= bound);
		if (slot_est >= (IDX_W+1)'(TABLE_SIZE)) begin
			slot_nx = IDX_W'(TABLE_SIZE - 1);
		end else begin
			slot_nx = slot_est[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q0_q   <= '0;
			slot_q <= '0;
		end else begin
			q0_q   <= slot_prod[30+IDX_W:31];
			slot_q <= slot_nx;
		end
	end

	always_comb begin
		diff      = {2'b0, rd_q} - {2'b0, gen2_q};
		diff_wrap = diff + {2'b0, WRAP_ADD};
		if (diff[32] || diff == '0) begin
			val = diff_wrap[30:0];
		end else begin
			val = diff[30:0];
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = slot_q;
		wr_data = gen1_q;
		if (ctl.warm) begin
			wr_en   = ({1'b0, cnt_q} < (CNT_W+1)'(TABLE_SIZE));
			wr_addr = cnt_q[IDX_W-1:0];
			wr_data = gen1_nx;
		end else if (ctl.upd) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen1_q  <= GEN1_RST;
			gen2_q  <= GEN2_RST;
			last_q  <= '0;
			cnt_q   <= '0;
			valid_q <= '0;
		end else begin
			if (ctl.seed) begin
				gen1_q <= seed_fix;
				gen2_q <= seed_fix;
				cnt_q  <= CNT_W'(TOP_CNT);
			end else if (ctl.warm) begin
				gen1_q <= gen1_nx;
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					last_q <= gen1_nx;
				end
			end else if (ctl.step) begin
				gen1_q <= gen1_nx;
				gen2_q <= gen2_nx;
			end else if (ctl.upd) begin
				last_q <= val;
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= valid_q[slot_q] ? mem[slot_q] : '0;
	end

	// floor(last * 2^24 / GEN1_MOD) is last>>7 or one more
	always_comb begin
		f0    = last_q[30:7];
		f_lhs = {8'(8'd128 - {1'b0, last_q[6:0]}), 24'b0};
		f_rhs = ({8'b0, f0} + 32'd1) * GEN1_FOLD;
		f_sum = {1'b0, f0} + 25'(f_lhs <= f_rhs);
		if (f_sum > {1'b0, FRAC_MAX}) begin
			frac = FRAC_MAX;
		end else begin
			frac = f_sum[23:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			int_q  <= last_q;
			frac_q <= frac;
		end
	end

	assign value_integer  = int_q;
	assign value_fraction = frac_q;

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, slot_q} < (IDX_W+1)'(TABLE_SIZE))
		else $error("shuffle slot out of table");

	a_fill_last: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.warm && stat.warm_last |=> last_q == gen1_q)
		else $error("last output not taken from final fill value");

	a_upd_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.upd |=> last_q != '0)
		else $error("combined output fell to zero");

endmodule

### src/clsr_ctrl.sv
`timescale 1ns / 1ps

module clsr_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  logic            action,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	input  clsr_pkg::stat_t stat,
	output clsr_pkg::ctl_t  ctl
);
	import clsr_pkg::*;

	typedef enum logic [3:0] {
		IDLE,
		WARM_MUL,
		WARM_RED,
		SETTLE_A,
		SETTLE_B,
		DRAW_MUL,
		DRAW_RED,
		DRAW_UPD,
		DRAW_OUT
	} state_t;

	state_t state_q;
	logic   s_tready_q;
	logic   m_tvalid_q;
	logic   s_fire;
	logic   out_free;

	assign s_fire   = s_tvalid && s_tready_q;
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = s_tready_q;
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		ctl.seed     = (state_q == IDLE) && s_fire && action;
		ctl.warm     = (state_q == WARM_RED);
		ctl.step     = (state_q == DRAW_RED);
		ctl.upd      = (state_q == DRAW_UPD);
		ctl.out_load = (state_q == DRAW_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			s_tready_q <= 1'b1;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && !ctl.out_load) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (s_fire) begin
						s_tready_q <= 1'b0;
						state_q    <= action ? WARM_MUL : DRAW_MUL;
					end
				end
				WARM_MUL: state_q <= WARM_RED;
				WARM_RED: begin
					state_q <= stat.warm_last ? SETTLE_A : WARM_MUL;
				end
				// slot index pipeline catches up with the new last output
				SETTLE_A: state_q <= SETTLE_B;
				SETTLE_B: state_q <= DRAW_MUL;
				DRAW_MUL: state_q <= DRAW_RED;
				DRAW_RED: state_q <= DRAW_UPD;
				DRAW_UPD: state_q <= DRAW_OUT;
				DRAW_OUT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						s_tready_q <= 1'b1;
						state_q    <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire |=> !s_tready)
		else $error("second beat accepted while busy");

	a_draw_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && !action |-> ##4 (state_q == DRAW_OUT))
		else $error("draw did not reach output stage in time");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |=> m_tvalid && s_tready)
		else $error("loaded result not presented");

endmodule

### src/combined_lcg_shuffle_rng_core.sv
`timescale 1ns / 1ps

// channel | dir | handshake          | payload
// s       | in  | s_tvalid/s_tready  | s_tdata: seed_value; s_tuser: action
// m       | out | m_tvalid/m_tready  | m_tdata: value_integer, value_fraction
//
// A draw runs from accept through generator multiply, modular fold, table
// combine and output load, then returns to accept.
// A reseed adds one warm-up step per table slot and warm-up round, each a
// multiply and a fold on the shared generator-1 unit, then a slot-index settle.
// Reset returns the generators to 1 and 123456789 and marks every table slot
// empty (reads as zero). A stalled result sits in the output register while
// the next beat is accepted; that beat waits at output load until it drains.

module combined_lcg_shuffle_rng_core #(
	parameter int TABLE_SIZE    = clsr_pkg::TABLE_SIZE_DEF,
	parameter int WARMUP_ROUNDS = clsr_pkg::WARMUP_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [30:0] seed_value, [31] zero
	input  logic [0:0]  s_tuser,   // [0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata    // [30:0] value_integer, [54:31] value_fraction, [55] zero
);
	import clsr_pkg::*;

	ctl_t        ctl;
	stat_t       stat;
	logic [30:0] value_integer;
	logic [23:0] value_fraction;

	clsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.action   (s_tuser[0]),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.ctl      (ctl)
	);

	clsr_datapath #(
		.TABLE_SIZE    (TABLE_SIZE),
		.WARMUP_ROUNDS (WARMUP_ROUNDS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.stat           (stat),
		.seed_value     (s_tdata[30:0]),
		.value_integer  (value_integer),
		.value_fraction (value_fraction)
	);

	assign m_tdata = {1'b0, value_fraction, value_integer};

endmodule

### tb/sv/combined_lcg_shuffle_rng_core_tb.sv
`timescale 1ns / 1ps

module combined_lcg_shuffle_rng_core_tb;
	import clsr_pkg::*;

	localparam int TBL_SIZE = TABLE_SIZE_DEF;
	localparam int WARMUP   = WARMUP_DEF;
	localparam longint SLOT_DIV = 1 + longint'(WRAP_ADD) / TBL_SIZE;

	localparam bit ACT_DRAW   = 1'b0;
	localparam bit ACT_RESEED = 1'b1;

	typedef struct packed {
		logic [VAL_W-1:0]  ival;
		logic [FRAC_W-1:0] frac;
	} draw_t;

	class draw_scoreboard;
		bit [VAL_W-1:0] gen1;
		bit [VAL_W-1:0] gen2;
		bit [VAL_W-1:0] prev_draw;
		bit [VAL_W-1:0] slots [TBL_SIZE];
		draw_t expected_draws [$];
		int errors;

		function new();
			gen1 = GEN1_RST;
			gen2 = GEN2_RST;
			prev_draw = '0;
			foreach (slots[i])
				slots[i] = '0;
			errors = 0;
		endfunction

		// (mul * x) mod m; the fold reduction in the block gives the same result
		function bit [VAL_W-1:0] mod_mul(bit [VAL_W-1:0] x, longint mul, longint modulus);
			longint r;
			r = (longint'(x) * mul) % modulus;
			return r[VAL_W-1:0];
		endfunction

		function void accept_request(bit act, bit [VAL_W-1:0] seed);
			int n;
			int idx;
			longint diff;
			longint scaled;
			draw_t d;
			if (act == ACT_RESEED) begin
				gen1 = (seed == '0) ? VAL_W'(1) : seed;
				gen2 = gen1;
				for (n = TBL_SIZE + WARMUP - 1; n >= 0; n--) begin
					gen1 = mod_mul(gen1, GEN1_MUL, longint'(GEN1_MOD));
					if (n < TBL_SIZE)
						slots[n] = gen1;
				end
				prev_draw = slots[0];
			end
			gen1 = mod_mul(gen1, GEN1_MUL, longint'(GEN1_MOD));
			gen2 = mod_mul(gen2, GEN2_MUL, longint'(GEN2_MOD));
			idx = int'(longint'(prev_draw) / SLOT_DIV);
			if (idx > TBL_SIZE - 1)
				idx = TBL_SIZE - 1;
			diff = longint'(slots[idx]) - longint'(gen2);
			slots[idx] = gen1;
			if (diff < 1)
				diff += longint'(WRAP_ADD);
			prev_draw = diff[VAL_W-1:0];
			scaled = (diff << FRAC_W) / longint'(GEN1_MOD);
			if (scaled > longint'(FRAC_MAX))
				scaled = longint'(FRAC_MAX);
			d.ival = prev_draw;
			d.frac = scaled[FRAC_W-1:0];
			expected_draws.push_back(d);
		endfunction

		function void check_draw(logic [55:0] beat);
			draw_t want;
			if (expected_draws.size() == 0) begin
				$error("result beat %h with nothing expected", beat);
				errors++;
				return;
			end
			want = expected_draws.pop_front();
			if (beat[30:0] !== want.ival) begin
				$error("value_integer: expected %0d, got %0d", want.ival, beat[30:0]);
				errors++;
			end
			if (beat[54:31] !== want.frac) begin
				$error("value_fraction: expected %0d, got %0d", want.frac, beat[54:31]);
				errors++;
			end
		endfunction
	endclass

	bit          clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [30:0] seed_value, [31] zero
	logic [0:0]  s_tuser;   // [0] action
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;   // [30:0] value_integer, [54:31] value_fraction, [55] zero

	draw_scoreboard sb = new();
	int gap_max = 8;
	int stall_max = 8;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	combined_lcg_shuffle_rng_core #(
		.TABLE_SIZE(TBL_SIZE),
		.WARMUP_ROUNDS(WARMUP)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// called at a falling edge, returns at the falling edge after the beat
	task automatic send_beat(input bit act, input bit [VAL_W-1:0] seed);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, seed};
		s_tuser  <= act;
		do
			@(posedge clk);
		while (!s_tready);
		sb.accept_request(act, seed);
		@(negedge clk);
	endtask

	// drops tvalid and holds off until every expected result is out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (sb.expected_draws.size() != 0);
	endtask

	function automatic bit [VAL_W-1:0] pick_seed();
		if ($urandom_range(0, 7) != 0)
			return VAL_W'($urandom());
		case ($urandom_range(0, 4))
			0:       return '0;
			1:       return GEN1_MOD;
			2:       return GEN2_MOD;
			3:       return '1;
			default: return WRAP_ADD;
		endcase
	endfunction

	// result side
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = $urandom_range(0, stall_max);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_tvalid);
			sb.check_draw(m_tdata);
			@(negedge clk);
		end
	end

	initial begin
		int sent;
		int run_len;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = ACT_DRAW;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// draws straight out of reset see an empty table
		repeat (3) send_beat(ACT_DRAW, VAL_W'($urandom()));
		send_beat(ACT_RESEED, '0);
		repeat (2) send_beat(ACT_DRAW, '0);
		send_beat(ACT_RESEED, 31'd1);
		send_beat(ACT_DRAW, '1);
		send_beat(ACT_RESEED, '1);
		send_beat(ACT_DRAW, '0);
		// generator 1 collapses to zero and stays there
		send_beat(ACT_RESEED, GEN1_MOD);
		repeat (3) send_beat(ACT_DRAW, '0);
		// generator 2 collapses to zero
		send_beat(ACT_RESEED, GEN2_MOD);
		repeat (2) send_beat(ACT_DRAW, '0);
		send_beat(ACT_RESEED, WRAP_ADD);
		send_beat(ACT_DRAW, '0);
		send_beat(ACT_RESEED, 31'h2AAA_AAAA);
		send_beat(ACT_RESEED, 31'h5555_5555);
		send_beat(ACT_DRAW, '0);
		wait_drained();

		sent = 0;
		while (sent < 950) begin
			gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 8;
			stall_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
			if ($urandom_range(0, 7) == 0) begin
				wait_drained();
			end
			if ($urandom_range(0, 5) != 0) begin
				send_beat(ACT_RESEED, pick_seed());
				sent++;
			end
			run_len = $urandom_range(8, 50);
			repeat (run_len) begin
				if ($urandom_range(0, 39) == 0)
					send_beat(ACT_RESEED, pick_seed());
				else
					send_beat(ACT_DRAW, VAL_W'($urandom()));
				sent++;
			end
		end

		wait_drained();
		repeat (2 * (TBL_SIZE + WARMUP) + 20) @(negedge clk);
		if (sb.errors == 0 && sb.expected_draws.size() == 0)
			$display("** combined_lcg_shuffle_rng_core: PASSED **");
		else
			$display("** combined_lcg_shuffle_rng_core: FAILED **");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("** combined_lcg_shuffle_rng_core: FAILED **");
		$finish;
	end

endmodule

### filelist.f
src/clsr_pkg.sv
src/clsr_mulmod.sv
src/clsr_datapath.sv
src/clsr_ctrl.sv
src/combined_lcg_shuffle_rng_core.sv
tb/sv/combined_lcg_shuffle_rng_core_tb.sv
